// ===== src/iar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_pkg: shared types and constants of the accel-to-gyro resampler
// widths of samples, timestamps, weights and the gyro wait store
// ----------------------------------------------------------------------------
package iar_pkg;
  localparam int WAIT_DEPTH  = 8;
  localparam int SAMPLE_BITS = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int TIME_BITS   = 63;
  localparam int NUM_AXES    = 3;
  localparam int IDX_BITS    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(WAIT_DEPTH + 1);
  localparam int WCNT_BITS   = $clog2(WEIGHT_BITS + 2);
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;

  localparam logic FUNC_ACCEL = 1'b0;
  localparam logic FUNC_GYRO  = 1'b1;

  typedef logic [TIME_BITS-1:0]          time_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WEIGHT_BITS:0]          weight_t;

  // gyro store entry, time and three axes
  typedef struct packed {
    time_t   t;
    sample_t x;
    sample_t y;
    sample_t z;
  } gyro_t;

  localparam int GYRO_BITS = $bits(gyro_t);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_BLEND = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;
endpackage

// ===== src/iar_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_stream_if: valid/ready channel with a generic payload
// source drives valid and payload, sink drives ready
// ----------------------------------------------------------------------------
interface iar_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/imu_accel_to_gyro_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_accel_to_gyro_resampler: gyro-rate fused records with interpolated accel
// gyro store in a ram, serial weight divider, three blend lanes
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_s      in    func, sample_time, axis_x/y/z
// out_m     out   fused_time, gyro_x/y/z, accel_x/y/z, last_of_run
//
// a gyro item outside the interval, the first accel item or an ignored accel item stays in ST_IDLE
// an accepted accel item after the first scans and compacts the stored entries in ST_SCAN
// each released record passes the divider (a step per weight bit, a rounding step,
// a closing step), then blend and output
// a late gyro inside the interval goes from accept straight to the divider
// reset clears state at once; a stalled output holds the fsm in ST_OUT or at scan end
// ----------------------------------------------------------------------------
module imu_accel_to_gyro_resampler (
  input logic clk_i,
  input logic rst_ni,
  iar_stream_if.sink   in_s,
  iar_stream_if.source out_m
);
  import iar_pkg::*;

  state_e state_q, state_d;
  time_t  older_t_q, newer_t_q;
  sample_t older_a_q [NUM_AXES];
  sample_t newer_a_q [NUM_AXES];
  logic [1:0] seen_q;
  logic [CNT_BITS-1:0] cnt_q, keep_q, scan_q;
  logic       from_scan_q;
  gyro_t      cur_q;
  logic [TIME_BITS:0] rem_q, den_q;
  weight_t    w_q;
  logic [WCNT_BITS-1:0] step_q;
  logic       last_q;

  logic       ram_we;
  logic [IDX_BITS-1:0] ram_addr;
  gyro_t      ram_wdata, ram_rdata;
  logic       rd_pend_q;

  logic       hold_v_q;
  logic       out_v_q;
  wire out_free = !out_v_q || out_m.ready;

  logic    in_func;
  time_t   in_t;
  sample_t in_a [NUM_AXES];
  assign in_func = in_s.payload.func;
  assign in_t    = in_s.payload.sample_time;
  assign in_a[0] = in_s.payload.axis_x;
  assign in_a[1] = in_s.payload.axis_y;
  assign in_a[2] = in_s.payload.axis_z;

  assign in_s.ready = (state_q == ST_IDLE);
  wire in_fire = in_s.valid && in_s.ready;

  iar_ram #(.WIDTH(GYRO_BITS), .DEPTH(WAIT_DEPTH)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // store port: gyro append in idle, reads and compaction writes in scan
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = IDX_BITS'(scan_q);
    ram_wdata = ram_rdata;
    if (state_q == ST_IDLE) begin
      ram_we    = in_fire && in_func == FUNC_GYRO && seen_q != 2'd0 && in_t >= newer_t_q
                  && cnt_q < CNT_BITS'(WAIT_DEPTH);
      ram_addr  = IDX_BITS'(cnt_q);
      ram_wdata = '{t: in_t, x: in_a[0], y: in_a[1], z: in_a[2]};
    end else if (state_q == ST_SCAN && rd_pend_q && ram_rdata.t >= newer_t_q) begin
      ram_we   = 1'b1;
      ram_addr = IDX_BITS'(keep_q);
    end
  end

  // blend lanes
  sample_t lane_res [NUM_AXES];
  wire lane_load = (state_q == ST_BLEND);
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    iar_lane u_lane (.clk_i, .load_i(lane_load), .older_i(older_a_q[g]),
                     .newer_i(newer_a_q[g]), .weight_i(w_q), .result_o(lane_res[g]));
  end

  // any stored entry left unread in this scan
  logic more_in_scan;
  assign more_in_scan = (scan_q < cnt_q);

  logic [TIME_BITS:0] rem_sh;
  assign rem_sh = {rem_q[TIME_BITS-1:0], 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_ACCEL) begin
            if (!(seen_q != 2'd0 && in_t <= newer_t_q) && seen_q != 2'd0) state_d = ST_SCAN;
          end else if (seen_q == 2'd2 && in_t < newer_t_q && in_t >= older_t_q) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_SCAN: begin
        if (rd_pend_q && ram_rdata.t < newer_t_q) state_d = ST_DIV;
        else if (!rd_pend_q && !more_in_scan && (!hold_v_q || out_free)) state_d = ST_IDLE;
      end
      ST_DIV:   if (step_q == WCNT_BITS'(WEIGHT_BITS + 1)) state_d = ST_BLEND;
      ST_BLEND: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = (from_scan_q && !last_q) ? ST_SCAN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      older_t_q   <= '0;
      newer_t_q   <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      keep_q      <= '0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      from_scan_q <= 1'b0;
      last_q      <= 1'b0;
      step_q      <= '0;
      for (int j = 0; j < NUM_AXES; j++) begin
        older_a_q[j] <= '0;
        newer_a_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (ram_we) cnt_q <= cnt_q + 1'b1;
          if (in_fire && in_func == FUNC_ACCEL && !(seen_q != 2'd0 && in_t <= newer_t_q)) begin
            older_t_q <= newer_t_q;
            newer_t_q <= in_t;
            for (int j = 0; j < NUM_AXES; j++) begin
              older_a_q[j] <= newer_a_q[j];
              newer_a_q[j] <= in_a[j];
            end
            if (seen_q != 2'd2) seen_q <= seen_q + 1'b1;
            keep_q    <= '0;
            scan_q    <= '0;
            rd_pend_q <= 1'b0;
          end
          if (state_d == ST_DIV) begin
            cur_q       <= '{t: in_t, x: in_a[0], y: in_a[1], z: in_a[2]};
            from_scan_q <= 1'b0;
            last_q      <= 1'b1;
            rem_q       <= {1'b0, in_t - older_t_q};
            den_q       <= {1'b0, newer_t_q - older_t_q};
            w_q         <= '0;
            step_q      <= '0;
          end
        end
        ST_SCAN: begin
          if (seen_q != 2'd2) begin
            // only one accel known: nothing releases
            rd_pend_q <= 1'b0;
            scan_q    <= cnt_q;
            keep_q    <= cnt_q;
          end else if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
            if (ram_rdata.t >= newer_t_q) begin
              keep_q <= keep_q + 1'b1;
            end else begin
              cur_q       <= ram_rdata;
              from_scan_q <= 1'b1;
              rem_q       <= {1'b0, ram_rdata.t - older_t_q};
              den_q       <= {1'b0, newer_t_q - older_t_q};
              w_q         <= '0;
              step_q      <= '0;
            end
          end else if (more_in_scan) begin
            rd_pend_q <= 1'b1;
            scan_q    <= scan_q + 1'b1;
          end else begin
            cnt_q <= keep_q;
          end
        end
        ST_DIV: begin
          // restoring divide, one weight bit per step, then a rounding step and a closing step
          step_q <= step_q + 1'b1;
          if (step_q < WCNT_BITS'(WEIGHT_BITS)) begin
            if (rem_sh >= den_q) begin
              rem_q <= rem_sh - den_q;
              w_q   <= {w_q[WEIGHT_BITS-1:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              w_q   <= {w_q[WEIGHT_BITS-1:0], 1'b0};
            end
          end else if (step_q == WCNT_BITS'(WEIGHT_BITS)) begin
            if (rem_sh >= den_q) w_q <= w_q + 1'b1;
            if (from_scan_q) last_q <= 1'b0;
          end
        end
        ST_BLEND: ;
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // a scan record is last when no unread entry lies before the new accel time;
  // look ahead is not possible from one port, so the scan defers the flag:
  // every scan record waits in hold_q until the next release or scan end
  typedef struct packed {
    time_t   t;
    sample_t gx, gy, gz, ax, ay, az;
  } rec_t;

  rec_t hold_q;
  rec_t out_q;
  logic out_last_q;

  // new record from the lanes, valid in ST_OUT
  rec_t new_rec;
  assign new_rec = '{t: cur_q.t, gx: cur_q.x, gy: cur_q.y, gz: cur_q.z,
                     ax: lane_res[0], ay: lane_res[1], az: lane_res[2]};

  wire scan_end = (state_q == ST_SCAN) && !rd_pend_q && !more_in_scan;

  // output register is loaded by a direct record, a displaced held record or the flush
  logic out_load;
  assign out_load = (state_q == ST_OUT && out_free && (!from_scan_q || hold_v_q))
                    || (scan_end && hold_v_q && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_m.ready) out_v_q <= 1'b0;
      if (state_q == ST_OUT && out_free) begin
        if (!from_scan_q) begin
          out_q      <= new_rec;
          out_last_q <= 1'b1;
        end else begin
          hold_q   <= new_rec;
          hold_v_q <= 1'b1;
          if (hold_v_q) begin
            out_q      <= hold_q;
            out_last_q <= 1'b0;
          end
        end
      end else if (scan_end && hold_v_q && out_free) begin
        out_q      <= hold_q;
        out_last_q <= 1'b1;
        hold_v_q   <= 1'b0;
      end
    end
  end

  assign out_m.valid                = out_v_q;
  assign out_m.payload.fused_time   = out_q.t;
  assign out_m.payload.gyro_x       = out_q.gx;
  assign out_m.payload.gyro_y       = out_q.gy;
  assign out_m.payload.gyro_z       = out_q.gz;
  assign out_m.payload.accel_x      = out_q.ax;
  assign out_m.payload.accel_y      = out_q.ay;
  assign out_m.payload.accel_z      = out_q.az;
  assign out_m.payload.last_of_run  = out_last_q;

  // assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(WAIT_DEPTH)) else $error("store count overflow");
  a_keep_le_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> keep_q <= scan_q) else $error("compaction ahead of scan");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == 2'd2 |-> older_t_q < newer_t_q) else $error("accel times out of order");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_v_q) else $error("held record left after scan");
endmodule

// ===== src/iar_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_ram: generic single-port ram with registered read
// one write and one read of the same address per cycle
// ----------------------------------------------------------------------------
module iar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/iar_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_lane: one axis blend lane
// older + round(|newer - older| * w / 2^WEIGHT_BITS), sign of the difference
// ----------------------------------------------------------------------------
module iar_lane (
  input  logic               clk_i,
  input  logic               load_i,
  input  iar_pkg::sample_t   older_i,
  input  iar_pkg::sample_t   newer_i,
  input  iar_pkg::weight_t   weight_i,
  output iar_pkg::sample_t   result_o
);
  import iar_pkg::*;

  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  logic [DIFF_BITS+WEIGHT_BITS:0] prod_q;
  logic                        neg_q;
  sample_t                     base_q;
  logic [DIFF_BITS-1:0]        q;
  logic signed [DIFF_BITS-1:0] sum;

  assign diff = DIFF_BITS'(newer_i) - DIFF_BITS'(older_i);
  assign mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : diff;

  // registered product, then rounding and sign in the next cycle
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= (DIFF_BITS+WEIGHT_BITS+1)'(mag) * (DIFF_BITS+WEIGHT_BITS+1)'(weight_i);
      neg_q  <= diff[DIFF_BITS-1];
      base_q <= older_i;
    end
  end

  // rounds the whole product half up before the shift
  assign q   = DIFF_BITS'((prod_q + (DIFF_BITS+WEIGHT_BITS+1)'(1 << (WEIGHT_BITS-1)))
                          >> WEIGHT_BITS);
  assign sum = neg_q ? (DIFF_BITS'(base_q) - $signed(q)) : (DIFF_BITS'(base_q) + $signed(q));
  assign result_o = sum[SAMPLE_BITS-1:0];
endmodule
